### rtl/muldiv_pkg.sv
// shared constants and types for the multiply-divide pipeline
package muldiv_pkg;

  localparam int PORT_BITS = 64;
  localparam int WORD_BITS_DEF = 64;

  typedef struct packed {
    logic qneg;
    logic pneg;
    logic dz;
  } muldiv_side_t;

endpackage

### rtl/muldiv_mul.sv
// split-product multiplier: partial products, then one summing stage
module muldiv_mul import muldiv_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [W-1:0]     ma,
  input  logic [W-1:0]     mb,
  input  logic [W-1:0]     mc,
  input  muldiv_side_t     in_side,
  output logic             out_valid,
  output logic [2*W-1:0]   prod,
  output logic [W-1:0]     out_d,
  output muldiv_side_t     out_side
);

  localparam int LO = W / 2;
  localparam int HI = W - LO;

  logic [2*LO-1:0]  pp_ll;
  logic [LO+HI-1:0] pp_lh;
  logic [LO+HI-1:0] pp_hl;
  logic [2*HI-1:0]  pp_hh;
  logic             pp_valid;
  logic [W-1:0]     pp_d;
  muldiv_side_t     pp_side;
  logic [2*W-1:0]   prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= in_valid;
    end
    pp_ll   <= ma[LO-1:0] * mb[LO-1:0];
    pp_lh   <= ma[LO-1:0] * mb[W-1:LO];
    pp_hl   <= ma[W-1:LO] * mb[LO-1:0];
    pp_hh   <= ma[W-1:LO] * mb[W-1:LO];
    pp_d    <= mc;
    pp_side <= in_side;
  end

  // align the cross terms and the high term
  assign prod_next = (2*W)'(pp_ll) + ((2*W)'(pp_lh) << LO)
                   + ((2*W)'(pp_hl) << LO) + ((2*W)'(pp_hh) << (2*LO));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pp_valid;
    end
    prod     <= prod_next;
    out_d    <= pp_d;
    out_side <= pp_side;
  end

endmodule

### rtl/muldiv_div.sv
// restoring divider, one quotient bit per pipeline stage
module muldiv_div import muldiv_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2*W-1:0]   num,
  input  logic [W-1:0]     d,
  input  muldiv_side_t     in_side,
  output logic             out_valid,
  output logic [2*W-1:0]   quo,
  output logic [W-1:0]     rem,
  output muldiv_side_t     out_side
);

  localparam int N = 2 * W;

  logic             v_s    [N];
  logic [W-1:0]     r_s    [N];
  logic [N-1:0]     nq_s   [N];
  logic [W-1:0]     d_s    [N];
  muldiv_side_t     side_s [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic         v_in;
    logic [W-1:0] r_in;
    logic [N-1:0] nq_in;
    logic [W-1:0] d_in;
    muldiv_side_t side_in;
    logic [W:0]   shifted;
    logic         ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign r_in    = '0;
      assign nq_in   = num;
      assign d_in    = d;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_s[i-1];
      assign r_in    = r_s[i-1];
      assign nq_in   = nq_s[i-1];
      assign d_in    = d_s[i-1];
      assign side_in = side_s[i-1];
    end

    // numerator bits shift out the top, quotient bits in at the bottom
    assign shifted = {r_in, nq_in[N-1]};
    assign ge      = shifted >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else begin
        v_s[i] <= v_in;
      end
      r_s[i]    <= ge ? W'(shifted - {1'b0, d_in}) : shifted[W-1:0];
      nq_s[i]   <= {nq_in[N-2:0], ge};
      d_s[i]    <= d_in;
      side_s[i] <= side_in;
    end
  end

  assign out_valid = v_s[N-1];
  assign quo       = nq_s[N-1];
  assign rem       = r_s[N-1];
  assign out_side  = side_s[N-1];

endmodule

### rtl/mul_div_with_remainder_top.sv
// top level of the signed multiply-then-divide pipeline
//
// computes (multiplicand * multiplier) / divisor on an exact double-width
// product, truncating toward zero, with the remainder taking the sign of
// the product
// input channel: an item is taken at a clock edge where start is high and
// busy is low; busy stays low, so an item may enter every cycle
// only the low WORD_BITS bits of each operand are used, sign-extended
// output channel: done is high for exactly one cycle with quotient,
// remainder_out, overflow and divide_by_zero; the receiver cannot stall
// path: from the accepting edge through the stages listed below to the
// registered result; throughput one item per cycle
// the restoring divider, one quotient bit per stage, makes up most of the path
// stages: operand magnitude, partial products, product sum, divider, result
// overflow: the low bits of the quotient are given and the flag is set
// divisor zero: quotient and remainder zero, divide_by_zero set
// reset clears all valid bits; items in flight are dropped
module mul_div_with_remainder_top import muldiv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PORT_BITS-1:0] multiplicand,
  input  logic [PORT_BITS-1:0] multiplier,
  input  logic [PORT_BITS-1:0] divisor,
  output logic                 done,
  output logic [PORT_BITS-1:0] quotient,
  output logic [PORT_BITS-1:0] remainder_out,
  output logic                 overflow,
  output logic                 divide_by_zero
);

  localparam int W = WORD_BITS;
  localparam int LATENCY = 2 * W + 4;

  // operand stage: sign and magnitude
  logic [W-1:0] a, b, c;
  logic         na, nb, nc;
  logic         in_valid;
  logic [W-1:0] ma, mb, mc;
  muldiv_side_t in_side;

  assign busy = 1'b0;
  assign a  = multiplicand[W-1:0];
  assign b  = multiplier[W-1:0];
  assign c  = divisor[W-1:0];
  assign na = a[W-1];
  assign nb = b[W-1];
  assign nc = c[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    ma           <= na ? W'(-a) : a;
    mb           <= nb ? W'(-b) : b;
    mc           <= nc ? W'(-c) : c;
    in_side.pneg <= na ^ nb;
    in_side.qneg <= na ^ nb ^ nc;
    in_side.dz   <= (c == '0);
  end

  // double-width unsigned product of the magnitudes
  logic           p_valid;
  logic [2*W-1:0] prod;
  logic [W-1:0]   p_d;
  muldiv_side_t   p_side;

  muldiv_mul #(.W(W)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ma        (ma),
    .mb        (mb),
    .mc        (mc),
    .in_side   (in_side),
    .out_valid (p_valid),
    .prod      (prod),
    .out_d     (p_d),
    .out_side  (p_side)
  );

  // unsigned division of the product by the divisor magnitude
  logic           q_valid;
  logic [2*W-1:0] quo;
  logic [W-1:0]   rem;
  muldiv_side_t   q_side;

  muldiv_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .num       (prod),
    .d         (p_d),
    .in_side   (p_side),
    .out_valid (q_valid),
    .quo       (quo),
    .rem       (rem),
    .out_side  (q_side)
  );

  // result stage: restore signs, range check, zero-divisor override
  logic [W-1:0] q_lo, q_signed, r_signed, limit;
  logic         ovf;

  assign q_lo     = quo[W-1:0];
  // a negative quotient may reach one further than a positive one
  assign limit    = q_side.qneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign ovf      = (quo[2*W-1:W] != '0) || (q_lo > limit);
  assign q_signed = q_side.qneg ? W'(-q_lo) : q_lo;
  assign r_signed = q_side.pneg ? W'(-rem) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
    if (q_side.dz) begin
      quotient       <= '0;
      remainder_out  <= '0;
      overflow       <= 1'b0;
      divide_by_zero <= 1'b1;
    end else begin
      quotient       <= PORT_BITS'(signed'(q_signed));
      remainder_out  <= PORT_BITS'(signed'(r_signed));
      overflow       <= ovf;
      divide_by_zero <= 1'b0;
    end
  end

  // every result traces back to an earlier clock edge with start high
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> quotient == '0 && remainder_out == '0)
    else $error("divide by zero with nonzero result");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(overflow && divide_by_zero))
    else $error("overflow and divide by zero together");

endmodule
